FILE: design/lpht_pkg.sv
// Shared types, codes and defaults for the linear probe hash table.
package lpht_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int HELD_W    = 6;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    localparam logic [1:0] CODE_DONE    = 2'd0;
    localparam logic [1:0] CODE_FULL    = 2'd1;
    localparam logic [1:0] CODE_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0]  result_value;
        logic [1:0]        result_code;
        logic [HELD_W-1:0] entries_held;
    } t_out_word;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

endpackage

FILE: design/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/linear_probe_hash_table_unit.sv
// Linear probe hash table: top level with request sequencer and slot memory.
//
// Key/value table of SLOTS slots in one RAM (used bit, key, value per slot),
// open addressing with linear probing from slot key mod SLOTS, wrapping at the
// end. After reset a clearing pass over all SLOTS slots marks every slot
// unused; no word is accepted during it. One request is handled at a time.
// For a power-of-two SLOTS a request passes an accept state, a RAM read
// state, one probe step per slot probed (1 to SLOTS slots, with the next
// slot's read issued while the current one is checked), and a result state
// that waits while the output register is full and stalled. For any other
// SLOTS the home slot comes from a reciprocal multiply in the accept state
// and a correcting subtract in one more state. An undefined operation goes
// from the accept state straight to the result state.
// A finished result sits in the output register while the next request is
// accepted.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    localparam int  IDX_W = $clog2(SLOTS);
    localparam int  CNT_W = $clog2(SLOTS + 1);
    localparam bit  POW2  = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(SLOTS - 1);
    localparam logic [IDX_W:0]   SLOT_DIV = (IDX_W + 1)'(SLOTS);
    // floor(2^32 / SLOTS): quotient estimate is low by at most one
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / 64'(SLOTS));

    t_state           r_state, n_state;
    logic [1:0]       r_func, n_func;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_val, n_val;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W:0]   r_quo, n_quo;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [VAL_W-1:0] r_rv, n_rv;
    logic [1:0]       r_code, n_code;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word, n_out_word;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry              rd_ent;

    lpht_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_slot),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = t_entry'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_val      <= n_val;
        r_cnt      <= n_cnt;
        r_quo      <= n_quo;
        r_rv       <= n_rv;
        r_code     <= n_code;
        r_out_word <= n_out_word;
    end

    always_comb begin
        logic [2*KEY_W-1:0] prod;
        logic [IDX_W:0]     fold;
        logic [IDX_W-1:0]   next_slot;
        logic               hit;

        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_val       = r_val;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_quo       = r_quo;
        n_occ       = r_occ;
        n_rv        = r_rv;
        n_code      = r_code;
        n_out_valid = r_out_valid && i_stall;
        n_out_word  = r_out_word;
        ram_we      = 1'b0;
        ram_waddr   = r_slot;
        ram_wdata   = '{used: 1'b1, key: r_key, value: r_val};

        // key mod SLOTS: only the low bits of key - quotient * SLOTS matter
        prod = (2*KEY_W)'(i_word.key) * (2*KEY_W)'(RECIP);
        fold = r_key[IDX_W:0] - r_quo * SLOT_DIV;
        if (fold >= SLOT_DIV) begin
            fold = fold - SLOT_DIV;
        end
        next_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + IDX_W'(1);
        hit = rd_ent.used && (rd_ent.key == r_key);

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '{used: 1'b0, key: '0, value: '0};
                if (r_slot == LAST_SLOT) begin
                    n_slot  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_slot = next_slot;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_word.func;
                    n_key  = i_word.key;
                    n_val  = i_word.value;
                    n_cnt  = '0;
                    n_rv   = '0;
                    n_code = CODE_DONE;
                    n_quo  = prod[KEY_W +: IDX_W + 1];
                    if (i_word.func == FUNC_INSERT || i_word.func == FUNC_REMOVE ||
                        i_word.func == FUNC_LOOKUP) begin
                        if (POW2) begin
                            n_slot  = i_word.key[IDX_W-1:0];
                            n_state = S_READ;
                        end else begin
                            n_state = S_MOD;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MOD: begin
                n_slot  = fold[IDX_W-1:0];
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!rd_ent.used) begin
                    if (r_func == FUNC_INSERT) begin
                        ram_we = 1'b1;
                        n_occ  = r_occ + CNT_W'(1);
                    end else begin
                        n_code = CODE_MISSING;
                    end
                    n_state = S_DONE;
                end else if (hit) begin
                    if (r_func == FUNC_INSERT) begin
                        ram_we = 1'b1;
                    end else if (r_func == FUNC_REMOVE) begin
                        ram_we    = 1'b1;
                        ram_wdata = '{used: 1'b0, key: r_key, value: rd_ent.value};
                        n_occ     = r_occ - CNT_W'(1);
                        n_rv      = rd_ent.value;
                    end else begin
                        n_rv = rd_ent.value;
                    end
                    n_state = S_DONE;
                end else if (r_cnt == LAST_PROBE) begin
                    n_code  = (r_func == FUNC_INSERT) ? CODE_FULL : CODE_MISSING;
                    n_state = S_DONE;
                end else begin
                    // issue the next slot's read while this one is checked
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_slot = next_slot;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{result_value: r_rv,
                                    result_code:  r_code,
                                    entries_held: HELD_W'(r_occ)};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;

endmodule
